// ===== rtl/dtt_pkg.sv =====
`default_nettype none
package dtt_pkg;
  localparam int TIMERS = 16;
  localparam int IW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam int CW = $clog2(TIMERS + 1);
  localparam logic [31:0] THRESHOLD_RESET = 32'd5000000;

  typedef enum logic [2:0] {
    ACT_REGISTER = 3'd0,
    ACT_CANCEL   = 3'd1,
    ACT_REFRESH  = 3'd2,
    ACT_RESET    = 3'd3,
    ACT_QUERY    = 3'd4,
    ACT_PROCESS  = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    ST_SUCCESS  = 2'd0,
    ST_INACTIVE = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_RD, S_RMW, S_SCAN, S_SCAN_DONE,
    S_EMIT, S_REARM, S_REARM_RD, S_REARM_WR
  } state_e;

  typedef enum logic [1:0] {
    P_EARLIEST, P_DUE, P_MIN_DUE
  } purpose_e;
endpackage
`default_nettype wire

// ===== rtl/deadline_timer_table_unit.sv =====
// Channel   Direction  Handshake              Payload
// input     in         in_valid_i/in_stall_o  action, now_us, handle, period_us, recurring, from_now
// result    out        out_valid_o/out_stall_i status, slot, delay_us, at_front, expired_valid, last
// config    in         cfg_we_i               cfg_wdata_i (rollover threshold)
// One transaction is worked on at a time. Register and query run one scan of the deadline
// memory, one slot per cycle; a reset that changes the timer runs one too. Process runs two
// scans plus one scan per expired timer; each recurring one also passes a read state to rearm.
// Reset clears the marks at once; no clearing pass. A stalled result holds the unit in its
// emit state; a scan itself never stalls.
`default_nettype none
module deadline_timer_table_unit import dtt_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  action_i,
  input  wire logic [63:0] now_us_i,
  input  wire logic [3:0]  handle_i,
  input  wire logic [63:0] period_us_i,
  input  wire logic        recurring_i,
  input  wire logic        from_now_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       status_o,
  output logic [3:0]       slot_o,
  output logic [63:0]      delay_us_o,
  output logic             at_front_o,
  output logic             expired_valid_o,
  output logic             last_o,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i
);

  logic [63:0] dl_mem [TIMERS];
  logic [63:0] per_mem [TIMERS];
  logic [63:0] rd_dl_q, rd_per_q;
  logic [IW-1:0] rd_addr, wr_addr;
  logic wr_dl, wr_per;
  logic [63:0] wr_dl_data, wr_per_data;

  state_e state_q, state_d, ret_q, ret_d;
  purpose_e purp_q, purp_d;
  logic [2:0] act_q;
  logic [63:0] now_q, per_q;
  logic [3:0] h_q;
  logic rec_q, fnow_q;
  logic [IW-1:0] slot_q, slot_d;
  logic best_q, best_d;
  logic [IW-1:0] best_idx_q, best_idx_d;
  logic [63:0] best_dl_q, best_dl_d;
  logic [TIMERS-1:0] due_q, due_d, active_q, active_d, recur_q, recur_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic rvalid_q, rvalid_d;
  logic [IW-1:0] ridx_q, ridx_d;
  logic front_q, front_d, roll_q, roll_d, lastr_q, lastr_d;
  logic [63:0] prev_q, prev_d;
  logic [31:0] thr_q;
  logic [1:0] rst_st_q, rst_st_d;
  logic [IW-1:0] rs_slot_q, rs_slot_d;
  logic [63:0] rs_dl_q, rs_dl_d;
  logic rs_fr_q, rs_fr_d, rs_ev_q, rs_ev_d, rs_la_q, rs_la_d;
  logic ov_q, ov_d, ofr_q, ofr_d, oev_q, oev_d, ola_q, ola_d;
  logic [1:0] ost_q, ost_d;
  logic [3:0] oslot_q, oslot_d;
  logic [63:0] odl_q, odl_d;

  logic [IW-1:0] hidx, free_idx;
  logic h_ok, free_ok, scan_mask;
  logic [63:0] start;

  assign hidx = IW'(h_q);
  assign h_ok = (int'(h_q) < TIMERS) && active_q[hidx];

  always_comb begin
    free_ok = 1'b0;
    free_idx = '0;
    for (int i = TIMERS - 1; i >= 0; i--) begin
      if (!active_q[i]) begin
        free_ok = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_dl_q <= dl_mem[rd_addr];
    rd_per_q <= per_mem[rd_addr];
    if (wr_dl) dl_mem[wr_addr] <= wr_dl_data;
    if (wr_per) per_mem[wr_addr] <= wr_per_data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q <= S_IDLE;
      purp_q <= P_EARLIEST;
      active_q <= '0;
      recur_q <= '0;
      front_q <= 1'b0;
      prev_q <= '0;
      thr_q <= THRESHOLD_RESET;
      ov_q <= 1'b0;
      cnt_q <= '0;
      rvalid_q <= 1'b0;
      best_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q <= ret_d;
      purp_q <= purp_d;
      active_q <= active_d;
      recur_q <= recur_d;
      front_q <= front_d;
      prev_q <= prev_d;
      if (cfg_we_i) thr_q <= cfg_wdata_i;
      ov_q <= ov_d;
      cnt_q <= cnt_d;
      rvalid_q <= rvalid_d;
      best_q <= best_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      act_q <= action_i;
      now_q <= now_us_i;
      h_q <= handle_i;
      per_q <= period_us_i;
      rec_q <= recurring_i;
      fnow_q <= from_now_i;
    end
    slot_q <= slot_d;
    best_idx_q <= best_idx_d;
    best_dl_q <= best_dl_d;
    due_q <= due_d;
    ridx_q <= ridx_d;
    roll_q <= roll_d;
    lastr_q <= lastr_d;
    rst_st_q <= rst_st_d;
    rs_slot_q <= rs_slot_d;
    rs_dl_q <= rs_dl_d;
    rs_fr_q <= rs_fr_d;
    rs_ev_q <= rs_ev_d;
    rs_la_q <= rs_la_d;
    ost_q <= ost_d;
    oslot_q <= oslot_d;
    odl_q <= odl_d;
    ofr_q <= ofr_d;
    oev_q <= oev_d;
    ola_q <= ola_d;
  end

  always_comb begin
    state_d = state_q;
    ret_d = ret_q;
    purp_d = purp_q;
    active_d = active_q;
    recur_d = recur_q;
    front_d = front_q;
    prev_d = prev_q;
    slot_d = slot_q;
    best_d = best_q;
    best_idx_d = best_idx_q;
    best_dl_d = best_dl_q;
    due_d = due_q;
    cnt_d = cnt_q;
    rvalid_d = 1'b0;
    ridx_d = ridx_q;
    roll_d = roll_q;
    lastr_d = lastr_q;
    rst_st_d = rst_st_q;
    rs_slot_d = rs_slot_q;
    rs_dl_d = rs_dl_q;
    rs_fr_d = rs_fr_q;
    rs_ev_d = rs_ev_q;
    rs_la_d = rs_la_q;
    ov_d = ov_q && out_stall_i;
    ost_d = ost_q;
    oslot_d = oslot_q;
    odl_d = odl_q;
    ofr_d = ofr_q;
    oev_d = oev_q;
    ola_d = ola_q;
    rd_addr = hidx;
    wr_addr = hidx;
    wr_dl = 1'b0;
    wr_per = 1'b0;
    wr_dl_data = now_q + rd_per_q;
    wr_per_data = per_q;
    start = fnow_q ? now_q : rd_dl_q - rd_per_q;

    scan_mask = (purp_q == P_MIN_DUE) ? due_q[ridx_q] : active_q[ridx_q];
    if (rvalid_q && scan_mask) begin
      if (purp_q == P_DUE) begin
        due_d[ridx_q] = roll_q || (rd_dl_q <= now_q);
      end else if (!best_q || rd_dl_q < best_dl_q) begin
        best_d = 1'b1;
        best_idx_d = ridx_q;
        best_dl_d = rd_dl_q;
      end
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        rst_st_d = ST_SUCCESS;
        rs_slot_d = '0;
        rs_dl_d = '0;
        rs_fr_d = 1'b0;
        rs_ev_d = 1'b0;
        rs_la_d = 1'b1;
        ret_d = S_IDLE;
        state_d = S_EMIT;
        cnt_d = '0;
        best_d = 1'b0;
        purp_d = P_EARLIEST;
        case (act_q)
          ACT_REGISTER: begin
            if (!free_ok) begin
              rst_st_d = ST_FULL;
            end else begin
              wr_addr = free_idx;
              wr_dl = 1'b1;
              wr_per = 1'b1;
              wr_dl_data = now_q + per_q;
              active_d[free_idx] = 1'b1;
              recur_d[free_idx] = rec_q;
              slot_d = free_idx;
              state_d = S_SCAN;
            end
          end
          ACT_CANCEL: begin
            if (!h_ok) rst_st_d = ST_INACTIVE;
            else active_d[hidx] = 1'b0;
          end
          ACT_REFRESH, ACT_RESET: begin
            if (!h_ok) rst_st_d = ST_INACTIVE;
            else state_d = S_RD;
          end
          ACT_QUERY, ACT_PROCESS: state_d = S_SCAN;
          default: rst_st_d = ST_INACTIVE;
        endcase
      end
      S_RD: state_d = S_RMW;
      S_RMW: begin
        state_d = S_EMIT;
        if (act_q == ACT_REFRESH) begin
          wr_dl = 1'b1;
        end else if (!(per_q == rd_per_q && !fnow_q)) begin
          wr_dl = 1'b1;
          wr_per = 1'b1;
          wr_dl_data = start + per_q;
          slot_d = hidx;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (int'(cnt_q) < TIMERS) begin
          rd_addr = cnt_q[IW-1:0];
          ridx_d = cnt_q[IW-1:0];
          rvalid_d = 1'b1;
          cnt_d = cnt_q + CW'(1);
        end else begin
          state_d = S_SCAN_DONE;
        end
      end
      S_SCAN_DONE: begin
        cnt_d = '0;
        state_d = S_EMIT;
        case (purp_q)
          P_EARLIEST: begin
            case (act_q)
              ACT_QUERY: begin
                front_d = 1'b0;
                rs_dl_d = !best_q ? '1 : (now_q >= best_dl_q ? '0 : best_dl_q - now_q);
              end
              ACT_PROCESS: begin
                if (!best_q) begin
                  rst_st_d = ST_INACTIVE;
                end else begin
                  roll_d = (now_q < prev_q) && ((prev_q - now_q) > {32'd0, thr_q});
                  prev_d = now_q;
                  if (!roll_d && best_dl_q > now_q) begin
                    rst_st_d = ST_INACTIVE;
                  end else begin
                    purp_d = P_DUE;
                    due_d = '0;
                    state_d = S_SCAN;
                  end
                end
              end
              default: begin
                if (best_q && best_idx_q == slot_q && !front_q) begin
                  rs_fr_d = 1'b1;
                  front_d = 1'b1;
                end
                if (act_q == ACT_REGISTER) rs_slot_d = slot_q;
              end
            endcase
          end
          P_DUE: begin
            purp_d = P_MIN_DUE;
            best_d = 1'b0;
            state_d = S_SCAN;
          end
          default: begin
            slot_d = best_idx_q;
            due_d[best_idx_q] = 1'b0;
            lastr_d = (due_q & ~(TIMERS'(1) << best_idx_q)) == '0;
            rs_slot_d = best_idx_q;
            rs_ev_d = 1'b1;
            rs_la_d = lastr_d;
            ret_d = S_REARM;
          end
        endcase
      end
      S_EMIT: begin
        if (!ov_q || !out_stall_i) begin
          ov_d = 1'b1;
          ost_d = rst_st_q;
          oslot_d = 4'(rs_slot_q);
          odl_d = rs_dl_q;
          ofr_d = rs_fr_q;
          oev_d = rs_ev_q;
          ola_d = rs_la_q;
          state_d = ret_q;
        end
      end
      S_REARM: begin
        rd_addr = slot_q;
        if (recur_q[slot_q]) begin
          state_d = S_REARM_RD;
        end else begin
          active_d[slot_q] = 1'b0;
          state_d = S_REARM_WR;
        end
      end
      S_REARM_RD: begin
        state_d = S_REARM_WR;
        rd_addr = slot_q;
      end
      S_REARM_WR: begin
        if (recur_q[slot_q]) begin
          wr_addr = slot_q;
          wr_dl = 1'b1;
        end
        best_d = 1'b0;
        cnt_d = '0;
        state_d = lastr_q ? S_IDLE : S_SCAN;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = ov_q;
  assign status_o = ost_q;
  assign slot_o = oslot_q;
  assign delay_us_o = odl_q;
  assign at_front_o = ofr_q;
  assign expired_valid_o = oev_q;
  assign last_o = ola_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(cnt_q) <= TIMERS) else $error("scan counter out of range");
  a_front_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(front_q) |-> (act_q == ACT_REGISTER || act_q == ACT_RESET))
    else $error("front notice raised by wrong action");
  a_expired_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && oev_q |-> ost_q == ST_SUCCESS) else $error("expired result with bad status");
  a_read_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rvalid_q |-> $past(state_q == S_SCAN)) else $error("scan data outside a scan");
endmodule
`default_nettype wire
